FILE: src/key_debounce_event_detector_top_assert.svh
// ----------------------------------------------------------------------------
// key debounce event detector assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_EVENT_DETECTOR_TOP_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KDED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kded assertion failed");

// next-cycle implication, disabled during reset
`define KDED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kded assertion failed");

`endif

FILE: src/kded_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kded_pkg
// widths, register indexes and reset values for the key debounce detector
// ----------------------------------------------------------------------------
package kded_pkg;

	localparam int unsigned CNT_W    = 8;
	localparam int unsigned PRESS_W  = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE     = 2'd0,
		REG_REPEAT_PER   = 2'd1,
		REG_REPEAT_START = 2'd2,
		REG_LONG_PRESS   = 2'd3
	} cfg_reg_t;

	localparam logic [CNT_W-1:0]   DEBOUNCE_RST     = 8'd2;
	localparam logic [CNT_W-1:0]   REPEAT_PER_RST   = 8'd10;
	localparam logic [CNT_W-1:0]   REPEAT_START_RST = 8'd100;
	localparam logic [PRESS_W-1:0] LONG_PRESS_RST   = 16'd200;

	localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

endpackage

FILE: src/key_debounce_event_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_detector_top
// single-key debouncer with auto-repeat, long press and short press events
// ----------------------------------------------------------------------------
// One transaction on the input channel is one scan tick of the raw active-low
// key level; each tick yields exactly one result on the output channel. The
// debounce, hold and press-time counters are updated in the cycle the tick is
// taken, and the result is held in an output register, so a tick can be taken
// every cycle while the output side keeps up (one tick per cycle sustained).
// The user writes configuration registers through the cfg port only while no
// tick is in flight; the block itself does not enforce this.
module key_debounce_event_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [kded_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kded_pkg::CFG_W-1:0]          cfg_data,
	// scan tick input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                key_level,
	// event output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                held,
	output logic                                just_pressed,
	output logic                                repeat_event,
	output logic                                long_event,
	output logic                                just_released,
	output logic                                short_event,
	output logic [kded_pkg::PRESS_W-1:0]        press_ticks,
	output logic                                any_activity
);

	logic [kded_pkg::CNT_W-1:0]   debounce_q;
	logic [kded_pkg::CNT_W-1:0]   repeat_per_q;
	logic [kded_pkg::CNT_W-1:0]   repeat_start_q;
	logic [kded_pkg::PRESS_W-1:0] long_press_q;

	logic                         down_q;
	logic [kded_pkg::CNT_W-1:0]   hold_q;
	logic [kded_pkg::PRESS_W-1:0] press_q;

	logic                         out_valid_q;
	logic                         held_q;
	logic                         pressed_q;
	logic                         repeat_q;
	logic                         long_q;
	logic                         released_q;
	logic                         short_q;
	logic [kded_pkg::PRESS_W-1:0] press_out_q;

	logic                         accept;
	logic [kded_pkg::CNT_W-1:0]   hold_inc;
	logic                         press_bump;
	logic [kded_pkg::PRESS_W-1:0] press_inc;

	logic                         down_d;
	logic [kded_pkg::CNT_W-1:0]   hold_d;
	logic [kded_pkg::PRESS_W-1:0] press_d;
	logic                         pressed_d;
	logic                         repeat_d;
	logic                         long_d;
	logic                         released_d;
	logic                         short_d;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= kded_pkg::DEBOUNCE_RST;
			repeat_per_q   <= kded_pkg::REPEAT_PER_RST;
			repeat_start_q <= kded_pkg::REPEAT_START_RST;
			long_press_q   <= kded_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (kded_pkg::cfg_reg_t'(cfg_index))
				kded_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_data[kded_pkg::CNT_W-1:0];
				kded_pkg::REG_REPEAT_PER:   repeat_per_q   <= cfg_data[kded_pkg::CNT_W-1:0];
				kded_pkg::REG_REPEAT_START: repeat_start_q <= cfg_data[kded_pkg::CNT_W-1:0];
				kded_pkg::REG_LONG_PRESS:   long_press_q   <= cfg_data[kded_pkg::PRESS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign hold_inc   = hold_q + kded_pkg::CNT_W'(1);
	assign press_bump = (press_q != kded_pkg::PRESS_MAX);
	assign press_inc  = press_bump ? press_q + kded_pkg::PRESS_W'(1) : press_q;

	// next state and events for one tick
	always_comb begin
		down_d     = down_q;
		hold_d     = hold_q;
		press_d    = press_q;
		pressed_d  = 1'b0;
		repeat_d   = 1'b0;
		long_d     = 1'b0;
		released_d = 1'b0;
		short_d    = 1'b0;
		if (!key_level) begin
			hold_d  = hold_inc;
			press_d = press_inc;
			if (!down_q) begin
				if (hold_inc == debounce_q) begin
					down_d    = 1'b1;
					press_d   = {{(kded_pkg::PRESS_W-kded_pkg::CNT_W){1'b0}}, debounce_q};
					pressed_d = 1'b1;
				end
			end else begin
				if (hold_inc == repeat_start_q) begin
					hold_d   = hold_inc - repeat_per_q;
					repeat_d = 1'b1;
				end
				long_d = press_bump && (press_inc == long_press_q);
			end
		end else begin
			hold_d = '0;
			if (down_q) begin
				down_d     = 1'b0;
				released_d = 1'b1;
				// press time kept from the last press decides short press
				short_d    = press_q <
					{{(kded_pkg::PRESS_W-kded_pkg::CNT_W){1'b0}}, repeat_start_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q  <= 1'b0;
			hold_q  <= '0;
			press_q <= '0;
		end else if (accept) begin
			down_q  <= down_d;
			hold_q  <= hold_d;
			press_q <= press_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result register, loaded with each accepted tick
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q      <= down_q;
			pressed_q   <= pressed_d;
			repeat_q    <= repeat_d;
			long_q      <= long_d;
			released_q  <= released_d;
			short_q     <= short_d;
			press_out_q <= press_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign held          = held_q;
	assign just_pressed  = pressed_q;
	assign repeat_event  = repeat_q;
	assign long_event    = long_q;
	assign just_released = released_q;
	assign short_event   = short_q;
	assign press_ticks   = press_out_q;
	assign any_activity  = held_q | pressed_q | repeat_q | long_q | released_q | short_q;

endmodule

FILE: src/kded_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kded_checker
// port-level checks for the key debounce event detector
// ----------------------------------------------------------------------------
`include "key_debounce_event_detector_top_assert.svh"

module kded_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         held,
	input  logic                         just_pressed,
	input  logic                         repeat_event,
	input  logic                         long_event,
	input  logic                         just_released,
	input  logic                         short_event,
	input  logic [kded_pkg::PRESS_W-1:0] press_ticks,
	input  logic                         any_activity
);

	// a stalled result transaction keeps its press time and held flag
	`KDED_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(press_ticks) && $stable(held))

	// a press is only accepted while the key was up, never with a release or a repeat
	`KDED_ASSERT_IMP(a_press_from_up, clk, arst_n, out_valid && just_pressed, !held && !just_released && !repeat_event)

	// release only follows a held key, short press only with a release
	`KDED_ASSERT_IMP(a_release_held, clk, arst_n, out_valid && just_released, held)
	`KDED_ASSERT_IMP(a_short_release, clk, arst_n, out_valid && short_event, just_released)

	`KDED_ASSERT_IMP(a_activity, clk, arst_n, out_valid, any_activity == (held || just_pressed || repeat_event || long_event || just_released || short_event))

endmodule

bind key_debounce_event_detector_top kded_checker u_kded_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.held          (held),
	.just_pressed  (just_pressed),
	.repeat_event  (repeat_event),
	.long_event    (long_event),
	.just_released (just_released),
	.short_event   (short_event),
	.press_ticks   (press_ticks),
	.any_activity  (any_activity)
);
